FILE: src/rrlsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrlsr_pkg
// shared types, character codes and small lookup functions for the
// receive-line to send-reply block
// ----------------------------------------------------------------------------
package rrlsr_pkg;

    // line parser states
    typedef enum logic [2:0] {
        PS_PRE,
        PS_WS,
        PS_SGN,
        PS_DIG,
        PS_PAY,
        PS_DONE,
        PS_FAIL
    } pst_t;

    // which numeric field is being scanned
    typedef enum logic [1:0] {
        F_ADDR,
        F_LEN,
        F_RSSI,
        F_SNR
    } fld_t;

    // source of an emitted reply byte
    typedef enum logic [2:0] {
        SRC_HEAD,
        SRC_DIGIT,
        SRC_COMMA,
        SRC_PAY,
        SRC_CR,
        SRC_LF
    } src_t;

    // reply sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_HEAD,
        S_WAITD,
        S_DIGD,
        S_COM1,
        S_WAITL,
        S_DIGL,
        S_COM2,
        S_PRD,
        S_PWR,
        S_CR,
        S_LF
    } ctl_state_t;

    typedef struct packed {
        logic accept_en;
        logic emit;
        src_t src;
        logic cnt_clr;
        logic cnt_set4;
        logic cnt_inc;
        logic cnt_dec;
        logic started_set;
        logic started_clr;
        logic conv_dest;
        logic conv_len;
        logic ram_rd;
    } cmd_t;

    typedef struct packed {
        logic line_ok;
        logic out_free;
        logic emit_last;
        logic conv_busy;
        logic cnt_zero;
        logic head_last;
        logic digit_zero;
        logic started;
        logic pay_last;
    } sts_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam logic [15:0] DEST_RESET = 16'd7;

    // "AT+SEND="
    function automatic logic [7:0] head_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0: ch = 8'h41;
            3'd1: ch = 8'h54;
            3'd2: ch = 8'h2B;
            3'd3: ch = 8'h53;
            3'd4: ch = 8'h45;
            3'd5: ch = 8'h4E;
            3'd6: ch = 8'h44;
            3'd7: ch = 8'h3D;
        endcase
        return ch;
    endfunction

    // "+RCV"
    function automatic logic [7:0] pre_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0: ch = 8'h2B;
            2'd1: ch = 8'h52;
            2'd2: ch = 8'h43;
            2'd3: ch = 8'h56;
        endcase
        return ch;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

FILE: src/rrlsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrlsr_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rrlsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/rrlsr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrlsr_dp
// datapath: line store, on-the-fly line parser, binary to bcd converter,
// reply byte mux and output register
// ----------------------------------------------------------------------------
module rrlsr_dp
    import rrlsr_pkg::*;
#(
    parameter int LINE_DEPTH    = 80,
    parameter int REPLY_DEPTH   = 64,
    parameter int PAYLOAD_BYTES = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        tx_valid,
    input  logic        tx_stall,
    output logic [7:0]  tx_byte,
    output logic        reply_end,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  cmd_t        cmd,
    output sts_t        sts
);

    localparam int AW  = $clog2(LINE_DEPTH);
    localparam int PLW = $clog2(PAYLOAD_BYTES);
    localparam int CW  = (PLW > 3) ? PLW : 3;
    localparam int EW  = $clog2(REPLY_DEPTH);
    localparam logic [AW-1:0]  FILL_MAX  = AW'(LINE_DEPTH - 1);
    localparam logic [PLW-1:0] PLEN_MAX  = PLW'(PAYLOAD_BYTES - 1);
    localparam logic [EW-1:0]  ECNT_LAST = EW'(REPLY_DEPTH - 2);

    // line and parser state
    logic [AW-1:0]  fill_reg, fill_next;
    pst_t           pst_reg, pst_next;
    fld_t           fld_reg, fld_next;
    logic           pre_ok_reg, pre_ok_next;
    logic           neg_reg, neg_next;
    logic [15:0]    val_reg, val_next;
    logic           addr_nz_reg, addr_nz_next;
    logic [15:0]    len_reg, len_next;
    logic [AW-1:0]  pstart_reg, pstart_next;
    logic [PLW-1:0] plen_reg, plen_next;
    logic           plong_reg, plong_next;

    // reply side
    logic [15:0]    dest_reg;
    logic [15:0]    bin_reg;
    logic [19:0]    bcd_reg;
    logic [4:0]     conv_cnt_reg;
    logic [CW-1:0]  cnt_reg;
    logic           started_reg;
    logic [EW-1:0]  ecnt_reg;
    logic           out_valid_reg;
    logic [7:0]     tx_byte_reg;
    logic           reply_end_reg;

    logic           acc, full, store, is_digit, end_ok_now, end_ok_next;
    logic [3:0]     dval;
    logic [15:0]    val_acc, val_fin;
    logic [7:0]     pay_data, emit_byte;
    logic [3:0]     cur_digit;
    logic [19:0]    bcd_adj;
    logic [AW-1:0]  rd_addr;
    logic           out_free;

    assign acc      = rx_valid && cmd.accept_en;
    assign rx_stall = !cmd.accept_en;
    assign full     = (fill_reg == FILL_MAX);
    assign store    = acc && !full;
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign dval     = rx_byte[3:0];
    assign val_acc  = 16'((val_reg << 3) + (val_reg << 1) + {12'd0, dval});
    assign val_fin  = neg_reg ? 16'(16'd0 - val_reg) : val_reg;
    assign end_ok_now  = (pst_reg == PS_DONE) || ((pst_reg == PS_DIG) && (fld_reg == F_SNR));
    assign end_ok_next = (pst_next == PS_DONE) || ((pst_next == PS_DIG) && (fld_next == F_SNR));

    // parser step for the incoming byte
    always_comb
    begin
        pst_next     = pst_reg;
        fld_next     = fld_reg;
        pre_ok_next  = pre_ok_reg;
        neg_next     = neg_reg;
        val_next     = val_reg;
        addr_nz_next = addr_nz_reg;
        len_next     = len_reg;
        pstart_next  = pstart_reg;
        plen_next    = plen_reg;
        plong_next   = plong_reg;
        if (rx_byte == CH_NUL)
        begin
            // nul ends the checked text
            pst_next = end_ok_now ? PS_DONE : PS_FAIL;
        end
        else
        begin
            unique case (pst_reg)
                PS_PRE:
                begin
                    if (rx_byte == CH_EQ)
                    begin
                        if ((fill_reg >= AW'(4)) && pre_ok_reg)
                        begin
                            pst_next = PS_WS;
                            fld_next = F_ADDR;
                            neg_next = 1'b0;
                            val_next = 16'd0;
                        end
                        else
                        begin
                            pst_next = PS_FAIL;
                        end
                    end
                    else if ((fill_reg < AW'(4)) && (rx_byte != pre_char(fill_reg[1:0])))
                    begin
                        pre_ok_next = 1'b0;
                    end
                end
                PS_WS:
                begin
                    if (is_space(rx_byte))
                    begin
                        pst_next = PS_WS;
                    end
                    else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))
                    begin
                        pst_next = PS_SGN;
                        neg_next = (rx_byte == CH_MINUS);
                    end
                    else if (is_digit)
                    begin
                        pst_next = PS_DIG;
                        val_next = {12'd0, dval};
                    end
                    else
                    begin
                        pst_next = PS_FAIL;
                    end
                end
                PS_SGN:
                begin
                    if (is_digit)
                    begin
                        pst_next = PS_DIG;
                        val_next = {12'd0, dval};
                    end
                    else
                    begin
                        pst_next = PS_FAIL;
                    end
                end
                PS_DIG:
                begin
                    if (is_digit)
                    begin
                        val_next = val_acc;
                    end
                    else
                    begin
                        unique case (fld_reg)
                            F_ADDR:
                            begin
                                if (rx_byte == CH_COMMA)
                                begin
                                    addr_nz_next = (val_fin != 16'd0);
                                    pst_next     = PS_WS;
                                    fld_next     = F_LEN;
                                    neg_next     = 1'b0;
                                    val_next     = 16'd0;
                                end
                                else
                                begin
                                    pst_next = PS_FAIL;
                                end
                            end
                            F_LEN:
                            begin
                                if (rx_byte == CH_COMMA)
                                begin
                                    len_next    = val_fin;
                                    pst_next    = PS_PAY;
                                    plen_next   = '0;
                                    plong_next  = 1'b0;
                                    pstart_next = AW'(fill_reg + 1'b1);
                                end
                                else
                                begin
                                    pst_next = PS_FAIL;
                                end
                            end
                            F_RSSI:
                            begin
                                if (rx_byte == CH_COMMA)
                                begin
                                    pst_next = PS_WS;
                                    fld_next = F_SNR;
                                    neg_next = 1'b0;
                                    val_next = 16'd0;
                                end
                                else
                                begin
                                    pst_next = PS_FAIL;
                                end
                            end
                            F_SNR:
                            begin
                                // trailing text after snr is ignored
                                pst_next = PS_DONE;
                            end
                        endcase
                    end
                end
                PS_PAY:
                begin
                    if (rx_byte == CH_COMMA)
                    begin
                        if ((plen_reg == '0) || plong_reg)
                        begin
                            pst_next = PS_FAIL;
                        end
                        else
                        begin
                            pst_next = PS_WS;
                            fld_next = F_RSSI;
                            neg_next = 1'b0;
                            val_next = 16'd0;
                        end
                    end
                    else if (plen_reg == PLEN_MAX)
                    begin
                        plong_next = 1'b1;
                    end
                    else
                    begin
                        plen_next = PLW'(plen_reg + 1'b1);
                    end
                end
                PS_DONE: pst_next = PS_DONE;
                PS_FAIL: pst_next = PS_FAIL;
                default: pst_next = PS_FAIL;
            endcase
        end
    end

    assign fill_next = store ? AW'(fill_reg + 1'b1) : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            pst_reg    <= PS_PRE;
            pre_ok_reg <= 1'b1;
        end
        else if (acc)
        begin
            if (full || (rx_byte == CH_LF))
            begin
                fill_reg   <= '0;
                pst_reg    <= PS_PRE;
                pre_ok_reg <= 1'b1;
            end
            else
            begin
                fill_reg   <= fill_next;
                pst_reg    <= pst_next;
                pre_ok_reg <= pre_ok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            fld_reg     <= fld_next;
            neg_reg     <= neg_next;
            val_reg     <= val_next;
            addr_nz_reg <= addr_nz_next;
            len_reg     <= len_next;
            pstart_reg  <= pstart_next;
            plen_reg    <= plen_next;
            plong_reg   <= plong_next;
        end
    end

    assign sts.line_ok = store && (rx_byte == CH_LF) && end_ok_next &&
                         addr_nz_reg && (len_reg != 16'd0);

    // line store
    assign rd_addr = AW'(32'(pstart_reg) + 32'(cnt_reg));

    rrlsr_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (store),
        .wr_addr (fill_reg),
        .wr_data (rx_byte),
        .rd_en   (cmd.ram_rd),
        .rd_addr (rd_addr),
        .rd_data (pay_data)
    );

    // destination register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_reg <= DEST_RESET;
        end
        else if (cfg_we)
        begin
            dest_reg <= cfg_wdata;
        end
    end

    // shift-add-3 converter, one bit a cycle
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                4'(bcd_reg[4*i +: 4] + 4'd3) : bcd_reg[4*i +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_cnt_reg <= '0;
        end
        else if (cmd.conv_dest || cmd.conv_len)
        begin
            conv_cnt_reg <= 5'd16;
        end
        else if (conv_cnt_reg != 5'd0)
        begin
            conv_cnt_reg <= 5'(conv_cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.conv_dest)
        begin
            bin_reg <= dest_reg;
            bcd_reg <= '0;
        end
        else if (cmd.conv_len)
        begin
            bin_reg <= len_reg;
            bcd_reg <= '0;
        end
        else if (conv_cnt_reg != 5'd0)
        begin
            {bcd_reg, bin_reg} <= {bcd_adj[18:0], bin_reg, 1'b0};
        end
    end

    always_comb
    begin
        unique case (cnt_reg[2:0])
            3'd0:    cur_digit = bcd_reg[3:0];
            3'd1:    cur_digit = bcd_reg[7:4];
            3'd2:    cur_digit = bcd_reg[11:8];
            3'd3:    cur_digit = bcd_reg[15:12];
            3'd4:    cur_digit = bcd_reg[19:16];
            default: cur_digit = 4'd0;
        endcase
    end

    // step counter shared by header, digits and payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_set4)
            begin
                cnt_reg <= CW'(4);
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= CW'(cnt_reg + 1'b1);
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= CW'(cnt_reg - 1'b1);
            end
            if (cmd.started_clr)
            begin
                started_reg <= 1'b0;
            end
            else if (cmd.started_set)
            begin
                started_reg <= 1'b1;
            end
        end
    end

    // reply byte select
    always_comb
    begin
        unique case (cmd.src)
            SRC_HEAD:  emit_byte = head_char(cnt_reg[2:0]);
            SRC_DIGIT: emit_byte = {4'h3, cur_digit};
            SRC_COMMA: emit_byte = CH_COMMA;
            SRC_PAY:   emit_byte = pay_data;
            SRC_CR:    emit_byte = CH_CR;
            SRC_LF:    emit_byte = CH_LF;
            default:   emit_byte = CH_LF;
        endcase
    end

    assign out_free = !out_valid_reg || !tx_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ecnt_reg      <= '0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!tx_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (sts.line_ok)
            begin
                ecnt_reg <= '0;
            end
            else if (cmd.emit)
            begin
                ecnt_reg <= EW'(ecnt_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            tx_byte_reg   <= emit_byte;
            reply_end_reg <= sts.emit_last || (cmd.src == SRC_LF);
        end
    end

    assign tx_valid  = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign reply_end = reply_end_reg;

    assign sts.out_free   = out_free;
    assign sts.emit_last  = (ecnt_reg == ECNT_LAST);
    assign sts.conv_busy  = (conv_cnt_reg != 5'd0);
    assign sts.cnt_zero   = (cnt_reg == '0);
    assign sts.head_last  = (cnt_reg == CW'(7));
    assign sts.digit_zero = (cur_digit == 4'd0);
    assign sts.started    = started_reg;
    assign sts.pay_last   = (CW'(cnt_reg + 1'b1) == CW'(plen_reg));

    a_conv_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.conv_dest || cmd.conv_len) |-> (conv_cnt_reg == 5'd0))
        else $error("converter restarted while busy");

    a_ecnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (ecnt_reg == ECNT_LAST)) |-> (cmd.src == SRC_LF || !sts.line_ok))
        else $error("reply longer than the output limit");

endmodule

FILE: src/rrlsr_ctl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrlsr_ctl
// reply sequencer: walks header, destination, length, payload and line end
// ----------------------------------------------------------------------------
module rrlsr_ctl
    import rrlsr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.src    = SRC_HEAD;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept_en = 1'b1;
                if (sts.line_ok)
                begin
                    cmd.conv_dest = 1'b1;
                    cmd.cnt_clr   = 1'b1;
                    state_next    = S_HEAD;
                end
            end
            S_HEAD:
            begin
                cmd.src = SRC_HEAD;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (sts.head_last)
                    begin
                        state_next = S_WAITD;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            S_WAITD, S_WAITL:
            begin
                if (!sts.conv_busy)
                begin
                    cmd.cnt_set4    = 1'b1;
                    cmd.started_clr = 1'b1;
                    state_next      = (state_reg == S_WAITD) ? S_DIGD : S_DIGL;
                end
            end
            S_DIGD, S_DIGL:
            begin
                cmd.src = SRC_DIGIT;
                if (!sts.started && sts.digit_zero && !sts.cnt_zero)
                begin
                    // leading zero
                    cmd.cnt_dec = 1'b1;
                end
                else if (sts.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.started_set = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (sts.cnt_zero)
                    begin
                        state_next = (state_reg == S_DIGD) ? S_COM1 : S_COM2;
                    end
                    else
                    begin
                        cmd.cnt_dec = 1'b1;
                    end
                end
            end
            S_COM1:
            begin
                cmd.src = SRC_COMMA;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.conv_len = 1'b1;
                        state_next   = S_WAITL;
                    end
                end
            end
            S_COM2:
            begin
                cmd.src = SRC_COMMA;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = S_PRD;
                    end
                end
            end
            S_PRD:
            begin
                cmd.ram_rd = 1'b1;
                state_next = S_PWR;
            end
            S_PWR:
            begin
                cmd.src = SRC_PAY;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (sts.pay_last)
                    begin
                        state_next = S_CR;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                        state_next  = S_PRD;
                    end
                end
            end
            S_CR:
            begin
                cmd.src = SRC_CR;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.emit_last ? S_IDLE : S_LF;
                end
            end
            S_LF:
            begin
                cmd.src = SRC_LF;
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("byte emitted into a full output register");

    a_line_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sts.line_ok |-> (state_reg == S_IDLE))
        else $error("line finished while a reply is in progress");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.emit_last) |=> (state_reg == S_IDLE))
        else $error("sequencer kept running after the last reply byte");

endmodule

FILE: src/radio_receive_line_to_send_reply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_receive_line_to_send_reply
// collects received characters into lines and answers each valid
// "+RCV...=addr,len,payload,rssi,snr" line with "AT+SEND=dest,len,payload\r\n"
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// rx        in         rx_valid / rx_stall  rx_byte[7:0]
// tx        out        tx_valid / tx_stall  tx_byte[7:0], reply_end
// cfg       in         cfg_we               cfg_wdata[15:0] (dest_address)
//
// an ordinary character is taken as soon as it is offered while no reply runs; the line is parsed as it
// arrives, so no rescan of the line store is needed
// after a valid newline rx is stalled while the reply runs: the destination
// conversion overlaps the header, the length conversion follows the first
// comma, leading zeros are skipped, and each payload byte is read through
// the line store read port before it is emitted
// tx_stall only holds the output register; the sequencer waits on it
// reset is asynchronous and clears the fill count and parser; the line store
// itself is never cleared
//
module radio_receive_line_to_send_reply
    import rrlsr_pkg::*;
#(
    parameter int LINE_DEPTH    = 80,
    parameter int REPLY_DEPTH   = 64,
    parameter int PAYLOAD_BYTES = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    // received characters
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    // reply characters
    output logic        tx_valid,
    input  logic        tx_stall,
    output logic [7:0]  tx_byte,
    output logic        reply_end,
    // destination address register
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    // parser, line store, converter and output register
    rrlsr_dp #(
        .LINE_DEPTH    (LINE_DEPTH),
        .REPLY_DEPTH   (REPLY_DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_byte   (rx_byte),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .tx_byte   (tx_byte),
        .reply_end (reply_end),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    // reply sequencer
    rrlsr_ctl u_ctl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

endmodule

FILE: dv/radio_receive_line_to_send_reply_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_receive_line_to_send_reply_test
// drives received lines (valid, malformed and noise) into the block and
// checks every reply character against a behavioral line parser
// ----------------------------------------------------------------------------
module radio_receive_line_to_send_reply_test;
    import rrlsr_pkg::*;

    localparam int LINE_DEPTH    = 80;
    localparam int REPLY_DEPTH   = 64;
    localparam int PAYLOAD_BYTES = 40;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } reply_char_t;

    // scoreboard: keeps its own copy of the line and the destination
    class reply_board;
        logic [7:0]  line_buf[LINE_DEPTH];
        int          fill;
        logic [15:0] dest;
        reply_char_t pending[$];
        int          errors;
        int          ecount;

        function void clear();
            fill = 0;
            dest = DEST_RESET;
            errors = 0;
            ecount = 0;
        endfunction

        // bytes of one reply beyond the output limit are dropped
        function void push_char(logic [7:0] c);
            reply_char_t r;
            if (ecount < REPLY_DEPTH - 1)
            begin
                r.ch = c;
                r.last = 1'b0;
                pending.push_back(r);
                ecount++;
            end
        endfunction

        function void push_dec(logic [15:0] v);
            string s;
            s = $sformatf("%0d", v);
            for (int k = 0; k < s.len(); k++)
                push_char(s[k]);
        endfunction

        // skips space, optional sign, digits; value taken modulo 65536
        function bit scan_num(ref int p, input int e, output logic [15:0] v);
            bit neg;
            int digits;
            neg = 0;
            digits = 0;
            v = 0;
            while (p < e && is_space(line_buf[p]))
                p++;
            if (p < e && (line_buf[p] == CH_PLUS || line_buf[p] == CH_MINUS))
            begin
                neg = line_buf[p] == CH_MINUS;
                p++;
            end
            while (p < e && line_buf[p] >= CH_ZERO && line_buf[p] <= CH_NINE)
            begin
                v = v * 16'd10 + 16'(line_buf[p] - CH_ZERO);
                p++;
                digits++;
            end
            if (neg)
                v = -v;
            return digits != 0;
        endfunction

        function void parse_line(int n);
            int e, p, ps, plen;
            logic [15:0] addr, len, junk;
            string head;
            e = n;
            for (int k = 0; k < n; k++)
                if (line_buf[k] == CH_NUL)
                begin
                    e = k;
                    break;
                end
            p = 0;
            while (p < e && line_buf[p] != CH_EQ)
                p++;
            if (p < 4 || p >= e)
                return;
            if (line_buf[0] != "+" || line_buf[1] != "R" || line_buf[2] != "C"
                || line_buf[3] != "V")
                return;
            p++;
            if (!scan_num(p, e, addr) || p >= e || line_buf[p] != CH_COMMA)
                return;
            p++;
            if (!scan_num(p, e, len) || p >= e || line_buf[p] != CH_COMMA)
                return;
            p++;
            ps = p;
            while (p < e && line_buf[p] != CH_COMMA)
                p++;
            plen = p - ps;
            if (plen == 0 || plen > PAYLOAD_BYTES - 1 || p >= e)
                return;
            p++;
            if (!scan_num(p, e, junk) || p >= e || line_buf[p] != CH_COMMA)
                return;
            p++;
            if (!scan_num(p, e, junk))
                return;
            if (addr == 0 || len == 0)
                return;
            ecount = 0;
            head = "AT+SEND=";
            for (int k = 0; k < 8; k++)
                push_char(head[k]);
            push_dec(dest);
            push_char(CH_COMMA);
            push_dec(len);
            push_char(CH_COMMA);
            for (int k = 0; k < plen; k++)
                push_char(line_buf[ps + k]);
            push_char(CH_CR);
            push_char(CH_LF);
            pending[pending.size() - 1].last = 1'b1;
        endfunction

        // note one accepted received item
        function void note_rx(logic [7:0] c);
            if (fill < LINE_DEPTH - 1)
            begin
                line_buf[fill] = c;
                fill++;
                if (c == CH_LF)
                begin
                    parse_line(fill);
                    fill = 0;
                end
            end
            else
                fill = 0;
        endfunction

        task check_tx(logic [7:0] c, logic last);
            reply_char_t r;
            if (pending.size() == 0)
                report_err($sformatf("unexpected reply char %02h", c));
            else
            begin
                r = pending.pop_front();
                if (r.ch !== c)
                    report_err($sformatf("tx_byte %02h, wanted %02h", c, r.ch));
                if (r.last !== last)
                    report_err($sformatf("reply_end %b, wanted %b", last, r.last));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        rx_valid;
    logic        rx_stall;
    logic [7:0]  rx_byte;
    logic        tx_valid;
    logic        tx_stall;
    logic [7:0]  tx_byte;
    logic        reply_end;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    reply_board board;
    int         fail_count;
    int         send_idle_pct;
    int         stall_pct;
    int         items_sent;

    radio_receive_line_to_send_reply i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_byte   (rx_byte),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .tx_byte   (tx_byte),
        .reply_end (reply_end),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // one line per mismatch, counted
    task automatic report_err(input string msg);
        fail_count++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // overall limit, far above the slowest run
    initial
    begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stall at the falling edge, check at the rising edge
    initial
    begin
        tx_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && tx_valid && !tx_stall)
                board.check_tx(tx_byte, reply_end);
            @(negedge clk);
            tx_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // one received item; idles first at random, then holds until taken
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= c;
        do
            @(posedge clk);
        while (rx_stall);
        board.note_rx(c);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_str(input string s);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k]);
    endtask

    // wait for all replies, then a margin for the block to settle
    task automatic drain();
        rx_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_dest(input logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.dest = v;
    endtask

    function automatic string rand_num(bit allow_sign);
        string s;
        s = "";
        repeat ($urandom_range(2)) s = {s, " "};
        if ($urandom_range(3) == 0)
            s = {s, "\t"};
        if (allow_sign && $urandom_range(2) == 0)
        begin
            if ($urandom_range(1) == 1)
                s = {s, "-"};
            else
                s = {s, "+"};
        end
        repeat ($urandom_range(6, 1))
            s = {s, string'(8'($urandom_range(9) + 48))};
        return s;
    endfunction

    function automatic string rand_payload(int n);
        string s;
        logic [7:0] c;
        s = "";
        for (int k = 0; k < n; k++)
        begin
            do
                c = 8'($urandom_range(255));
            while (c == CH_COMMA || c == CH_LF || c == CH_NUL);
            s = {s, string'(c)};
        end
        return s;
    endfunction

    // well formed line with random content, sometimes broken
    task automatic send_random_line();
        string pre, s;
        int plen;
        pre = "+RCV";
        if ($urandom_range(3) == 0)
            pre = {pre, rand_payload($urandom_range(3))};
        plen = ($urandom_range(9) == 0) ? $urandom_range(42, 1) : $urandom_range(12, 1);
        s = {pre, "=", rand_num(1), ",", rand_num(1), ",", rand_payload(plen), ",",
             rand_num(1), ",", rand_num(1)};
        if ($urandom_range(4) == 0)
            s = {s, "x"};
        // break one character now and then
        if ($urandom_range(7) == 0)
            s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
        send_str(s);
        send_char(CH_LF);
    endtask

    initial
    begin
        board = new();
        board.clear();
        fail_count = 0;
        items_sent = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        rx_valid = 1'b0;
        rx_byte = 8'h00;
        cfg_we = 1'b0;
        cfg_wdata = 16'h0000;
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed lines: reset destination, extremes, special cases
        send_str("+RCV=1,5,HELLO,-40,7\n");
        send_str("+RCVxyz= +65535,\t65535,A,+0,-0 trailing\n");
        send_str("+RCV=-1,-65535,ab,1,2\n");            // negated values
        send_str("+RCV=0,3,abc,1,2\n");                 // zero address
        send_str("+RCV=65536,3,abc,1,2\n");             // wraps to zero
        send_str("+RCV=4,3,,1,2\n");                    // empty payload
        send_str("+RCV=4,3,abcdefghijklmnopqrstuvwxyz0123456789ABC,1,2\n");
        send_str("+RCV=4,3,abcdefghijklmnopqrstuvwxyz0123456789ABCD,1,2\n");
        send_str("+RC=4,3,abc,1,2\n");                  // short preamble
        send_str("+RCV4,3,abc,1,2\n");                  // no equals
        send_str("+RCV=4 ,3,abc,1,2\n");                // space before comma
        send_str("+RCV=4,3,abc,1,\n");                  // missing snr
        send_str("+RCV=4,3,ab");
        send_char(CH_NUL);                               // zero ends the text
        send_str("c,1,2\n");
        send_str("+RCV=\v\f\r 9,8,pp,1,-\n");            // sign without digits
        for (int k = 0; k < 85; k++)                    // store full
            send_char(8'h41 + 8'(k % 26));
        send_str("+RCV=2,2,ok,1,1\n");
        for (int k = 0; k < 256; k += 37)
            send_char(8'(k));
        send_char(8'hFF);
        send_char(CH_LF);

        write_dest(16'd0);
        send_str("+RCV=2,2,zz,1,1\n");
        write_dest(16'hFFFF);
        send_str("+RCV=2,65535,maxdest,1,1\n");

        // random part over the idle phases
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 72;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 72;
                end
                default:
                begin
                    send_idle_pct = 27;
                    stall_pct = 27;
                end
            endcase
            write_dest(16'($urandom_range(65535)));
            send_random_line();
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(20)) send_char(8'($urandom_range(255)));
            while (items_sent < 500 + 25 * (ph + 1))
            begin
                if ($urandom_range(5) == 0)
                    repeat ($urandom_range(12)) send_char(8'($urandom_range(255)));
                else
                    send_random_line();
            end
            // hold off until every reply has come
            drain();
        end

        drain();
        if (fail_count == 0 && board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
